>>> design/ifba_pkg.sv
// Package for the flow byte accounting block: command codes, status codes and
// the item type passed from front end to back end. No dependencies.
`timescale 1ns / 1ps
package ifba_pkg;

    localparam logic [15:0] PREFIX_RESET    = 16'hC0A8;
    localparam logic [31:0] THRESHOLD_RESET = 32'd52428800;

    localparam logic CFG_PREFIX    = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_LOCAL   = 2'd1;
    localparam logic [1:0] ST_MARTIAN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic        dump_req;
        logic [1:0]  cls;
        logic [31:0] loc;
        logic [31:0] rem;
        logic [15:0] len;
        logic [31:0] hour;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDUMP,
        S_LOOKUP,
        S_STATUS,
        S_TDUMP
    } t_state;

endpackage

>>> design/ifba_front.sv
// Front end: captures a command, classifies it by the local prefix and puts it
// in a two-entry queue. Depends on ifba_pkg.
`timescale 1ns / 1ps
module ifba_front
    import ifba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_kind,
    input  logic [31:0] i_src,
    input  logic [31:0] i_dst,
    input  logic [15:0] i_len,
    input  logic [31:0] i_hour,
    input  logic [15:0] i_prefix,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_item       o_item
);
    t_item      r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    t_item      w_new;
    logic       w_sl, w_dl;

    always_comb begin
        w_sl = i_src[31:16] == i_prefix;
        w_dl = i_dst[31:16] == i_prefix;
        w_new.dump_req = i_kind;
        w_new.len = i_len;
        w_new.hour = i_hour;
        w_new.loc = w_sl ? i_src : i_dst;
        w_new.rem = w_sl ? i_dst : i_src;
        if (w_sl && w_dl) begin
            w_new.cls = ST_LOCAL;
            w_new.loc = i_src;
            w_new.rem = i_dst;
        end else if (!w_sl && !w_dl) begin
            w_new.cls = ST_MARTIAN;
            w_new.loc = i_src;
            w_new.rem = i_dst;
        end else begin
            w_new.cls = ST_COUNTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= w_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_full = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item = r_q[r_rd];
endmodule

>>> design/ifba_back.sv
// Back end: flow table, lookup, counting and dump sequencer.
// Depends on ifba_pkg.
`timescale 1ns / 1ps
module ifba_back
    import ifba_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [31:0] i_threshold,
    output logic        o_pop,
    output logic        o_busy,
    output logic        o_strobe,
    output logic        o_record_type,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_index,
    output logic [31:0] o_local_addr,
    output logic [31:0] o_remote_addr,
    output logic [63:0] o_byte_count,
    output logic [31:0] o_stat_hour,
    output logic        o_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [31:0] r_loc [TABLE_DEPTH];
    logic [31:0] r_rem [TABLE_DEPTH];
    logic [63:0] r_bytes [TABLE_DEPTH];

    t_state      r_state, n_state;
    t_item       r_it;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ptr;
    logic [31:0] r_hour, r_unsaved;
    logic [TABLE_DEPTH-1:0] r_hit;

    logic [TABLE_DEPTH-1:0] w_match;
    logic        w_found;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_slot;
    logic [63:0] w_old, w_nb;
    logic [64:0] w_bsum;
    logic [32:0] w_usum;
    logic [31:0] w_unew;
    logic        w_dump_more;

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            w_match[i] = (CW'(i) < r_count) && r_loc[i] == r_it.loc && r_rem[i] == r_it.rem;
    end

    always_comb begin
        w_found = |r_hit;
        w_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (r_hit[i]) w_idx = IW'(i);
        w_slot = w_found ? w_idx : r_count[IW-1:0];
        w_old = w_found ? r_bytes[w_slot] : 64'd0;
        w_bsum = {1'b0, w_old} + {49'd0, r_it.len};
        w_nb = w_bsum[64] ? '1 : w_bsum[63:0];
        w_usum = {1'b0, r_unsaved} + {17'd0, r_it.len};
        w_unew = w_usum[32] ? '1 : w_usum[31:0];
    end

    wire w_full = r_it.cls == ST_COUNTED && !w_found && r_count == DEPTH_C;
    wire w_count_pkt = r_it.cls == ST_COUNTED && !w_full;
    wire w_tdump = w_count_pkt && w_unew >= i_threshold;
    assign w_dump_more = r_ptr + 1'b1 < r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                if (i_item.dump_req) n_state = (r_count != '0) ? S_TDUMP : S_IDLE;
                else if (i_item.hour != r_hour && r_count != '0) n_state = S_HDUMP;
                else n_state = S_LOOKUP;
            end
            S_HDUMP:  if (!w_dump_more) n_state = S_LOOKUP;
            S_LOOKUP: n_state = S_STATUS;
            S_STATUS: n_state = w_tdump ? S_TDUMP : S_IDLE;
            S_TDUMP:  if (!w_dump_more) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_hour <= '0;
            r_unsaved <= '0;
            r_ptr <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    r_ptr <= '0;
                    if (i_valid) begin
                        r_it <= i_item;
                        // The old hour stays until the old table has been dumped.
                        if (!i_item.dump_req && i_item.hour != r_hour) begin
                            r_unsaved <= '0;
                            if (r_count == '0) r_hour <= i_item.hour;
                        end
                    end
                end
                S_HDUMP: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (!w_dump_more) begin
                        r_count <= '0;
                        r_hour <= r_it.hour;
                    end
                end
                S_LOOKUP: r_hit <= w_match;
                S_STATUS: begin
                    r_ptr <= '0;
                    if (w_count_pkt) begin
                        r_bytes[w_slot] <= w_nb;
                        if (!w_found) begin
                            r_loc[w_slot] <= r_it.loc;
                            r_rem[w_slot] <= r_it.rem;
                            r_count <= r_count + 1'b1;
                        end
                        r_unsaved <= (w_unew >= i_threshold) ? 32'd0 : w_unew;
                    end
                end
                S_TDUMP: r_ptr <= r_ptr + 1'b1;
                default: ;
            endcase
        end
    end

    // Output register: one result per cycle in dump and status states.
    logic [IW-1:0] w_p;
    assign w_p = r_ptr[IW-1:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else o_strobe <= r_state == S_HDUMP || r_state == S_STATUS || r_state == S_TDUMP;
        o_stat_hour <= r_hour;
        if (r_state == S_STATUS) begin
            o_record_type <= 1'b0;
            o_status <= w_full ? ST_FULL : r_it.cls;
            o_entry_index <= w_count_pkt ? 5'(w_slot) : 5'd0;
            o_local_addr <= r_it.loc;
            o_remote_addr <= r_it.rem;
            o_byte_count <= w_count_pkt ? w_nb : 64'd0;
            o_last <= !w_tdump;
        end else begin
            o_record_type <= 1'b1;
            o_status <= ST_COUNTED;
            o_entry_index <= 5'(w_p);
            o_local_addr <= r_loc[w_p];
            o_remote_addr <= r_rem[w_p];
            o_byte_count <= r_bytes[w_p];
            o_last <= r_state == S_TDUMP && !w_dump_more;
        end
    end

    assign o_pop = r_state == S_IDLE && i_valid;
    assign o_busy = r_state != S_IDLE;
endmodule

>>> design/ip_flow_byte_accounting_core.sv
// Per-flow IPv4 byte accounting core. A packet passes through the front-end
// queue and then the back end's lookup and status states, after an hour-change
// dump of a non-empty table if its hour differs; the status result is registered.
// A dump request on an empty table gives no record. The core takes no new packet
// until the last one has left the back end. Synchronous active-low reset
// clears counts, hour and the unsaved total; the table contents are undefined
// until written. The receiver cannot stall.
`timescale 1ns / 1ps
module ip_flow_byte_accounting_core
    import ifba_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_dst_addr,
    input  logic [15:0] i_packet_length,
    input  logic [31:0] i_current_hour,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic        o_record_type,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_index,
    output logic [31:0] o_local_addr,
    output logic [31:0] o_remote_addr,
    output logic [63:0] o_byte_count,
    output logic [31:0] o_stat_hour,
    output logic        o_last
);
    // Configuration registers are always writable.
    logic [15:0] r_prefix;
    logic [31:0] r_threshold;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= PREFIX_RESET;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PREFIX) r_prefix <= i_cfg_data[15:0];
            else r_threshold <= i_cfg_data;
        end
    end

    logic  w_full, w_valid, w_pop, w_bbusy, w_push;
    t_item w_item;

    // An item is held off while the queue is full or holds an item or the back end
    // still works, which keeps the queue to at most one waiting item.
    assign busy = w_full || w_bbusy || w_valid;
    assign w_push = start && !busy;

    ifba_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_kind(i_kind),
        .i_src(i_src_addr), .i_dst(i_dst_addr), .i_len(i_packet_length),
        .i_hour(i_current_hour), .i_prefix(r_prefix), .i_pop(w_pop),
        .o_full(w_full), .o_valid(w_valid), .o_item(w_item)
    );

    ifba_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_item(w_item),
        .i_threshold(r_threshold), .o_pop(w_pop), .o_busy(w_bbusy),
        .o_strobe(o_strobe), .o_record_type(o_record_type), .o_status(o_status),
        .o_entry_index(o_entry_index), .o_local_addr(o_local_addr),
        .o_remote_addr(o_remote_addr), .o_byte_count(o_byte_count),
        .o_stat_hour(o_stat_hour), .o_last(o_last)
    );

    // The queue never overflows.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push) else $error("push into full queue");
    // A pop only happens with an item queued.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_valid) else $error("pop from empty queue");
endmodule
